FILE: hw/rtl/wirp_pkg.sv
// Shared widths, constants and interface types for the isotonic regression block.
package wirp_pkg;

    // Default configuration of the top level.
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    // Fixed field widths.
    localparam int SAMPLE_W = 32;
    localparam int WIN_W    = 16;
    localparam int OUT_W    = 32;

    // Pool storage widths: exact weighted sum and total weight.
    localparam int SUM_W = 54;
    localparam int WT_W  = 22;

    // Cross-multiply compare: the sum is split into two halves.
    localparam int HALF_W    = SUM_W / 2;
    localparam int ACC_W     = SUM_W + WT_W + 1;
    localparam int CMP_CNT_W = 3;
    localparam logic [CMP_CNT_W-1:0] CMP_MUL_END = 3'd4;
    localparam logic [CMP_CNT_W-1:0] CMP_LAST    = 3'd5;

    // Bit-serial divider: one quotient bit per cycle.
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W);

    // Status returned by the mean compare unit.
    typedef struct packed {
        logic done;
        logic le;
    } cmp_res_t;

    // Status returned by the divider.
    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] quot;
    } div_res_t;

endpackage

FILE: hw/rtl/wirp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wirp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds when no read is issued.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/wirp_cmp.sv
// Exact pool mean compare: sum_a*wt_b <= sum_b*wt_a on one shared multiplier.
module wirp_cmp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [wirp_pkg::SUM_W-1:0] sum_a,
    input  logic [wirp_pkg::WT_W-1:0]        wt_a,
    input  logic signed [wirp_pkg::SUM_W-1:0] sum_b,
    input  logic [wirp_pkg::WT_W-1:0]        wt_b,
    output wirp_pkg::cmp_res_t               res
);

    localparam int PRD_W = wirp_pkg::HALF_W + wirp_pkg::WT_W + 2;

    logic [wirp_pkg::CMP_CNT_W-1:0]      cnt_reg;
    logic                                busy_reg;
    logic                                done_reg;
    logic                                le_reg;
    logic [1:0]                          step;
    logic [1:0]                          pstep_reg;
    logic signed [wirp_pkg::SUM_W-1:0]   sum_op;
    logic [wirp_pkg::WT_W-1:0]           wt_op;
    logic signed [wirp_pkg::HALF_W:0]    op_a;
    logic signed [wirp_pkg::WT_W:0]      op_b;
    logic signed [PRD_W-1:0]             prod;
    logic signed [PRD_W-1:0]             prod_reg;
    logic signed [wirp_pkg::ACC_W-1:0]   prod_ext;
    logic signed [wirp_pkg::ACC_W-1:0]   addend;
    logic signed [wirp_pkg::ACC_W-1:0]   acc_x_reg;
    logic signed [wirp_pkg::ACC_W-1:0]   acc_y_reg;
    logic                                mul_en;
    logic                                acc_en;

    // Steps 0 and 1 build sum_a*wt_b (low half, high half); steps 2 and 3 build sum_b*wt_a.
    assign step   = cnt_reg[1:0];
    assign sum_op = step[1] ? sum_b : sum_a;
    assign wt_op  = step[1] ? wt_a : wt_b;
    assign op_a   = step[0] ? {sum_op[wirp_pkg::SUM_W-1], sum_op[wirp_pkg::SUM_W-1:wirp_pkg::HALF_W]}
                            : {1'b0, sum_op[wirp_pkg::HALF_W-1:0]};
    assign op_b   = {1'b0, wt_op};
    assign prod   = op_a * op_b;

    // Multiply in the first four steps, accumulate one step behind.
    assign mul_en = busy_reg && (cnt_reg < wirp_pkg::CMP_MUL_END);
    assign acc_en = busy_reg && (cnt_reg != '0) && (cnt_reg <= wirp_pkg::CMP_MUL_END);

    // Align the registered partial product; the high half carries a shift by the half width.
    assign prod_ext = {{(wirp_pkg::ACC_W - PRD_W){prod_reg[PRD_W-1]}}, prod_reg};
    assign addend   = pstep_reg[0] ? (prod_ext <<< wirp_pkg::HALF_W) : prod_ext;

    // Step sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == wirp_pkg::CMP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Product register, accumulators and the final signed compare.
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg  <= prod;
            pstep_reg <= step;
        end
        if (start)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (acc_en)
        begin
            if (pstep_reg[1])
            begin
                acc_y_reg <= acc_y_reg + addend;
            end
            else
            begin
                acc_x_reg <= acc_x_reg + addend;
            end
        end
        if (busy_reg && (cnt_reg == wirp_pkg::CMP_LAST))
        begin
            le_reg <= (acc_x_reg <= acc_y_reg);
        end
    end

    assign res.done = done_reg;
    assign res.le   = le_reg;

endmodule

FILE: hw/rtl/wirp_div.sv
// Bit-serial restoring divider giving the floor of a signed pool sum over its weight.
module wirp_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [wirp_pkg::SUM_W-1:0] dividend,
    input  logic [wirp_pkg::WT_W-1:0]         divisor,
    output wirp_pkg::div_res_t                res
);

    logic [wirp_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic                           neg_reg;
    logic [wirp_pkg::SUM_W-1:0]     dvd_reg;
    logic [wirp_pkg::WT_W-1:0]      rem_reg;
    logic [wirp_pkg::WT_W-1:0]      dvs_reg;
    logic [wirp_pkg::OUT_W-1:0]     quot_reg;
    logic [wirp_pkg::SUM_W-1:0]     mag_in;
    logic [wirp_pkg::WT_W:0]        trial;
    logic [wirp_pkg::WT_W:0]        diff;
    logic                           fits;
    logic [wirp_pkg::SUM_W-1:0]     q_floor;

    // Magnitude of the dividend; the sign is applied again at the end.
    assign mag_in = dividend[wirp_pkg::SUM_W-1] ? (~$unsigned(dividend) + 1'b1)
                                                : $unsigned(dividend);

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, dvd_reg[wirp_pkg::SUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Floor for a negative sum: -q when exact, -q-1 (that is ~q) otherwise.
    assign q_floor = !neg_reg ? dvd_reg
                   : ((rem_reg != '0) ? ~dvd_reg : (~dvd_reg + 1'b1));

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == wirp_pkg::DIV_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[wirp_pkg::SUM_W-1];
            dvd_reg <= mag_in;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == wirp_pkg::DIV_LAST)
            begin
                quot_reg <= q_floor[wirp_pkg::OUT_W-1:0];
            end
            else
            begin
                dvd_reg <= {dvd_reg[wirp_pkg::SUM_W-2:0], fits};
                rem_reg <= fits ? diff[wirp_pkg::WT_W-1:0] : trial[wirp_pkg::WT_W-1:0];
            end
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

FILE: hw/rtl/weighted_isotonic_regression_pava.sv
// Weighted isotonic regression (pool adjacent violators): pool stack, merge sequencer, emission.
//
// Samples arrive one transaction at a time and the block is busy until each is folded
// into the pool stack. A sample passes through accept, check and write; every exact mean
// compare against the pool below adds a pool read, four passes through the shared 28x23
// multiplier and a 77-bit compare. On the final sample the block emits one result per
// loaded sample, in order: each pool first goes through its bit-serial division (one
// quotient bit per cycle over 54 bits) and each result is then held until out_ready is high.
// Pools live in one RAM of MAX_SAMPLES entries with a single read port and a single
// write port. Samples beyond MAX_SAMPLES are dropped and flagged on capacity_overflow of
// every result of that run.
module weighted_isotonic_regression_pava #(
    parameter int MAX_SAMPLES = wirp_pkg::MAX_SAMPLES_DEF,
    parameter int VALUE_BITS  = wirp_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [wirp_pkg::SAMPLE_W-1:0] sample_value,
    input  logic [wirp_pkg::WIN_W-1:0]           sample_weight,
    input  logic                                 segment_end,
    input  logic                                 final_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [wirp_pkg::OUT_W-1:0]    fitted_value,
    output logic [wirp_pkg::WT_W-1:0]            pool_total_weight,
    output logic                                 pool_first,
    output logic                                 last_result,
    output logic                                 capacity_overflow
);

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int PROD_W = VALUE_BITS + wirp_pkg::WIN_W + 1;
    localparam int ENT_W  = wirp_pkg::SUM_W + wirp_pkg::WT_W + IDX_W;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CHECK  = 9'b000000010,
        ST_RDWAIT = 9'b000000100,
        ST_CMP    = 9'b000001000,
        ST_WRITE  = 9'b000010000,
        ST_ERD    = 9'b000100000,
        ST_ELD    = 9'b001000000,
        ST_EDIV   = 9'b010000000,
        ST_EOUT   = 9'b100000000
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;

    // Run bookkeeping.
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    floor_reg;
    logic [CNT_W-1:0]                    loaded_reg;
    logic                                ovf_reg;
    logic [IDX_W-1:0]                    top_reg;
    logic [IDX_W-1:0]                    p_reg;
    logic [CNT_W-1:0]                    idx_reg;
    logic [CNT_W-1:0]                    end_reg;
    logic                                first_reg;

    // Pool being pushed, kept in registers until it settles.
    logic signed [wirp_pkg::SUM_W-1:0]   nv_sum_reg;
    logic [wirp_pkg::WT_W-1:0]           nv_wt_reg;
    logic [IDX_W-1:0]                    nv_start_reg;
    logic                                fin_reg;
    logic                                seg_reg;

    // Emission payload.
    logic [wirp_pkg::OUT_W-1:0]          mean_reg;
    logic [wirp_pkg::WT_W-1:0]           cur_wt_reg;

    // Intake arithmetic.
    logic signed [VALUE_BITS-1:0]        v_in;
    logic [wirp_pkg::WIN_W-1:0]          w_in;
    logic signed [PROD_W-1:0]            prod_in;
    logic signed [wirp_pkg::SUM_W-1:0]   sum_in;
    logic [wirp_pkg::WT_W-1:0]           wt_in;

    // RAM ports and unpacked read data.
    logic                                ram_we;
    logic                                ram_re;
    logic [IDX_W-1:0]                    ram_raddr;
    logic [ENT_W-1:0]                    ram_wdata;
    logic [ENT_W-1:0]                    ram_rdata;
    logic signed [wirp_pkg::SUM_W-1:0]   rd_sum;
    logic [wirp_pkg::WT_W-1:0]           rd_wt;
    logic [IDX_W-1:0]                    rd_start;

    // Control terms.
    logic                                in_fire;
    logic                                out_fire;
    logic                                room;
    logic [CNT_W-1:0]                    top_ext;
    logic                                can_merge;
    logic                                has_next;
    logic [CNT_W-1:0]                    idx_inc;
    logic                                cmp_start;
    logic                                div_start;
    wirp_pkg::cmp_res_t                  cmp_res;
    wirp_pkg::div_res_t                  div_res;

    // Take the low VALUE_BITS of the sample as two's complement; a zero weight counts as one.
    assign v_in    = sample_value[VALUE_BITS-1:0];
    assign w_in    = (sample_weight == '0) ? wirp_pkg::WIN_W'(1) : sample_weight;
    assign prod_in = v_in * $signed({1'b0, w_in});
    assign sum_in  = {{(wirp_pkg::SUM_W - PROD_W){prod_in[PROD_W-1]}}, prod_in};
    assign wt_in   = {{(wirp_pkg::WT_W - wirp_pkg::WIN_W){1'b0}}, w_in};

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign room      = (loaded_reg < CNT_W'(MAX_SAMPLES));
    assign top_ext   = CNT_W'(top_reg);
    assign can_merge = (top_ext > floor_reg);
    assign has_next  = ((CNT_W'(p_reg) + 1'b1) < count_reg);
    assign idx_inc   = idx_reg + 1'b1;

    // Pool entry layout: sum, weight, first sample index.
    assign ram_wdata = {nv_sum_reg, nv_wt_reg, nv_start_reg};
    assign rd_sum    = ram_rdata[ENT_W-1 -: wirp_pkg::SUM_W];
    assign rd_wt     = ram_rdata[wirp_pkg::WT_W+IDX_W-1 -: wirp_pkg::WT_W];
    assign rd_start  = ram_rdata[IDX_W-1:0];

    // RAM access: pool below the new one while merging, pool p and p+1 while emitting.
    always_comb
    begin
        ram_we    = (state_reg == ST_WRITE);
        ram_re    = 1'b0;
        ram_raddr = p_reg;
        case (state_reg)
            ST_CHECK:
            begin
                ram_re    = can_merge;
                ram_raddr = top_reg - 1'b1;
            end
            ST_ERD:
            begin
                ram_re    = 1'b1;
                ram_raddr = p_reg;
            end
            ST_ELD:
            begin
                ram_re    = has_next;
                ram_raddr = p_reg + 1'b1;
            end
            default:
            begin
                ram_re    = 1'b0;
                ram_raddr = p_reg;
            end
        endcase
    end

    assign cmp_start = (state_reg == ST_RDWAIT);
    assign div_start = (state_reg == ST_ELD);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (room)
                    begin
                        state_next = ST_CHECK;
                    end
                    else if (final_sample)
                    begin
                        state_next = ST_ERD;
                    end
                end
            end
            ST_CHECK:
            begin
                state_next = can_merge ? ST_RDWAIT : ST_WRITE;
            end
            ST_RDWAIT:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (cmp_res.done)
                begin
                    state_next = cmp_res.le ? ST_CHECK : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = fin_reg ? ST_ERD : ST_IDLE;
            end
            ST_ERD:
            begin
                state_next = ST_ELD;
            end
            ST_ELD:
            begin
                state_next = ST_EDIV;
            end
            ST_EDIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_EOUT;
                end
            end
            ST_EOUT:
            begin
                if (out_fire)
                begin
                    if (idx_inc == loaded_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (idx_inc == end_reg)
                    begin
                        state_next = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers: stack depth, segment floor, counters and indices.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            floor_reg  <= '0;
            loaded_reg <= '0;
            ovf_reg    <= 1'b0;
            top_reg    <= '0;
            p_reg      <= '0;
            idx_reg    <= '0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_IDLE) && in_fire)
            begin
                if (room)
                begin
                    top_reg    <= count_reg[IDX_W-1:0];
                    loaded_reg <= loaded_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if ((state_reg == ST_CMP) && cmp_res.done && cmp_res.le)
            begin
                top_reg <= top_reg - 1'b1;
            end
            if (state_reg == ST_WRITE)
            begin
                count_reg <= top_ext + 1'b1;
                if (seg_reg)
                begin
                    floor_reg <= top_ext + 1'b1;
                end
            end
            if ((state_reg == ST_EDIV) && div_res.done)
            begin
                first_reg <= 1'b1;
            end
            // After the last result the run state returns to empty.
            if ((state_reg == ST_EOUT) && out_fire)
            begin
                first_reg <= 1'b0;
                if (idx_inc == loaded_reg)
                begin
                    count_reg  <= '0;
                    floor_reg  <= '0;
                    loaded_reg <= '0;
                    ovf_reg    <= 1'b0;
                    idx_reg    <= '0;
                    p_reg      <= '0;
                end
                else
                begin
                    idx_reg <= idx_inc;
                    if (idx_inc == end_reg)
                    begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Payload registers: the pool being pushed and the current emission pool.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_fire)
        begin
            fin_reg      <= final_sample;
            seg_reg      <= segment_end;
            nv_sum_reg   <= sum_in;
            nv_wt_reg    <= wt_in;
            nv_start_reg <= loaded_reg[IDX_W-1:0];
        end
        if ((state_reg == ST_CMP) && cmp_res.done && cmp_res.le)
        begin
            nv_sum_reg   <= nv_sum_reg + rd_sum;
            nv_wt_reg    <= nv_wt_reg + rd_wt;
            nv_start_reg <= rd_start;
        end
        if (state_reg == ST_ELD)
        begin
            cur_wt_reg <= rd_wt;
        end
        // Read data now holds the next pool, whose first index ends this one.
        if ((state_reg == ST_EDIV) && div_res.done)
        begin
            mean_reg <= div_res.quot;
            end_reg  <= has_next ? CNT_W'(rd_start) : loaded_reg;
        end
    end

    // Pool storage.
    wirp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SAMPLES)
    ) u_pool_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (top_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Lower pool is a (from RAM), new pool is b; both hold steady during the compare.
    wirp_cmp u_cmp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmp_start),
        .sum_a (rd_sum),
        .wt_a  (rd_wt),
        .sum_b (nv_sum_reg),
        .wt_b  (nv_wt_reg),
        .res   (cmp_res)
    );

    wirp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_sum),
        .divisor  (rd_wt),
        .res      (div_res)
    );

    // Handshakes and result fields.
    assign in_ready          = (state_reg == ST_IDLE);
    assign out_valid         = (state_reg == ST_EOUT);
    assign fitted_value      = mean_reg;
    assign pool_total_weight = cur_wt_reg;
    assign pool_first        = first_reg;
    assign last_result       = (idx_inc == loaded_reg);
    assign capacity_overflow = ovf_reg;

endmodule

FILE: hw/rtl/wirp_chk.sv
// Port-level checker for the isotonic regression block, bound to the top level.
module wirp_chk (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 final_sample,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [wirp_pkg::OUT_W-1:0]    fitted_value,
    input logic                                 last_result,
    input logic                                 capacity_overflow
);

    // The block never takes a sample while it is emitting results.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while results are pending");

    // A non-final sample produces no result in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !final_sample) |=> !out_valid)
        else $error("result appeared after a non-final sample");

    // After the last result of a run the output side goes quiet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_result) |=> !out_valid)
        else $error("result after the last result of a run");

    // The overflow flag is constant across the results of one run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_result) |=> $stable(capacity_overflow))
        else $error("overflow flag changed within a run");

    // A stalled result transaction keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(fitted_value)))
        else $error("stalled result changed");

endmodule

bind weighted_isotonic_regression_pava wirp_chk u_wirp_chk (.*);

FILE: tb/tb.sv
// Self-checking testbench for the weighted isotonic regression (pool adjacent violators) block.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_SAMPLES = wirp_pkg::MAX_SAMPLES_DEF;
    localparam int VALUE_BITS  = wirp_pkg::VALUE_BITS_DEF;
    localparam int SAMPLE_W    = wirp_pkg::SAMPLE_W;
    localparam int WIN_W       = wirp_pkg::WIN_W;
    localparam int OUT_W       = wirp_pkg::OUT_W;
    localparam int WT_W        = wirp_pkg::WT_W;
    localparam int ITEM_TARGET = 320;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 200;
    localparam int REPORT_MAX  = 10;

    // One fitted output, laid out like the result ports.
    typedef struct packed {
        logic signed [OUT_W-1:0] fitted;
        logic [WT_W-1:0]         total_wt;
        logic                    first;
        logic                    last;
        logic                    overflow;
    } fit_t;

    // Tracks the pool stack of the block and holds the fitted values still owed by it.
    class pava_fit_tracker;
        fit_t   fitted_queue[$];
        longint pool_sum[MAX_SAMPLES];
        int     pool_wt[MAX_SAMPLES];
        int     pool_start[MAX_SAMPLES];
        int     n_pools;
        int     seg_floor;
        int     n_loaded;
        bit     dropped;
        int     errors;

        function new();
            n_pools   = 0;
            seg_floor = 0;
            n_loaded  = 0;
            dropped   = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return fitted_queue.size();
        endfunction

        // Exact test that the mean of pool a does not exceed the mean of pool b.
        function bit mean_not_greater(int a, int b);
            logic signed [127:0] sa, sb, wa, wb;
            sa = pool_sum[a];
            sb = pool_sum[b];
            wa = pool_wt[a];
            wb = pool_wt[b];
            return (sa * wb) <= (sb * wa);
        endfunction

        // Folds one accepted sample into the pool stack; on the final sample the
        // fitted values of the whole run are queued.
        function void add_sample(logic signed [SAMPLE_W-1:0] value,
                                 logic [WIN_W-1:0] weight, bit seg_end, bit fin);
            longint v;
            longint mean;
            longint rem;
            int     w;
            int     top;
            int     stop;
            fit_t   fit;
            // The low VALUE_BITS bits of the field are the value, in two's complement.
            v = longint'(value) & ((longint'(1) <<< VALUE_BITS) - 1);
            if (v[VALUE_BITS-1])
                v = v - (longint'(1) <<< VALUE_BITS);
            w = (weight == '0) ? 1 : int'(weight);

            if (n_loaded < MAX_SAMPLES)
            begin
                top = n_pools;
                pool_sum[top]   = v * longint'(w);
                pool_wt[top]    = w;
                pool_start[top] = n_loaded;
                n_loaded++;
                while (top > seg_floor && mean_not_greater(top - 1, top))
                begin
                    pool_sum[top - 1] += pool_sum[top];
                    pool_wt[top - 1] = (pool_wt[top - 1] + pool_wt[top]) & 32'h003F_FFFF;
                    top--;
                end
                n_pools = top + 1;
                if (seg_end)
                    seg_floor = n_pools;
            end
            else
            begin
                dropped = 1'b1;
            end

            if (fin)
            begin
                for (int p = 0; p < n_pools; p++)
                begin
                    stop = (p + 1 < n_pools) ? pool_start[p + 1] : n_loaded;
                    // Floor of the pool mean; division truncates, so step down on a
                    // negative remainder.
                    mean = pool_sum[p] / longint'(pool_wt[p]);
                    rem  = pool_sum[p] % longint'(pool_wt[p]);
                    if (rem != 0 && pool_sum[p] < 0)
                        mean -= 1;
                    for (int i = pool_start[p]; i < stop; i++)
                    begin
                        fit.fitted   = mean[OUT_W-1:0];
                        fit.total_wt = pool_wt[p][WT_W-1:0];
                        fit.first    = (i == pool_start[p]);
                        fit.last     = (i + 1 == n_loaded);
                        fit.overflow = dropped;
                        fitted_queue.push_back(fit);
                    end
                end
                n_pools   = 0;
                seg_floor = 0;
                n_loaded  = 0;
                dropped   = 1'b0;
            end
        endfunction

        // Compares one accepted result with the oldest owed fitted value.
        function void check_fit(fit_t got);
            fit_t want;
            if (fitted_queue.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: value %0d weight %0d first %0b last %0b ovf %0b",
                             got.fitted, got.total_wt, got.first, got.last, got.overflow);
                return;
            end
            want = fitted_queue.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"mismatch: expected value %0d weight %0d first %0b last %0b",
                              " ovf %0b, got value %0d weight %0d first %0b last %0b ovf %0b"},
                             want.fitted, want.total_wt, want.first, want.last, want.overflow,
                             got.fitted, got.total_wt, got.first, got.last, got.overflow);
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_value = '0;
    logic [WIN_W-1:0]           sample_weight = '0;
    logic                       segment_end = 1'b0;
    logic                       final_sample = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [OUT_W-1:0]    fitted_value;
    logic [WT_W-1:0]            pool_total_weight;
    logic                       pool_first;
    logic                       last_result;
    logic                       capacity_overflow;

    pava_fit_tracker fit_model = new();
    int  cycles = 0;
    int  loaded_total = 0;
    bit  valid_up = 1'b0;
    bit  in_burst = 1'b0;
    bit  out_burst = 1'b0;

    weighted_isotonic_regression_pava dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample_value      (sample_value),
        .sample_weight     (sample_weight),
        .segment_end       (segment_end),
        .final_sample      (final_sample),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .fitted_value      (fitted_value),
        .pool_total_weight (pool_total_weight),
        .pool_first        (pool_first),
        .last_result       (last_result),
        .capacity_overflow (capacity_overflow)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stall before each transaction, none in burst mode.
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Every accepted result is checked at the edge that takes it.
    always @(posedge clk)
    begin : result_monitor
        fit_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.fitted   = fitted_value;
            got.total_wt = pool_total_weight;
            got.first    = pool_first;
            got.last     = last_result;
            got.overflow = capacity_overflow;
            fit_model.check_fit(got);
        end
    end

    task automatic drop_valid();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // Presents one sample after a random gap and waits for its transaction.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] value, logic [WIN_W-1:0] weight,
                               bit seg_end, bit fin);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            drop_valid();
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        valid_up      = 1'b1;
        sample_value  <= value;
        sample_weight <= weight;
        segment_end   <= seg_end;
        final_sample  <= fin;
        do @(posedge clk); while (!in_ready);
        fit_model.add_sample(value, weight, seg_end, fin);
    endtask

    // Holds the sender back until every owed result has been taken.
    task automatic wait_drained();
        drop_valid();
        while (fit_model.pending() != 0) @(posedge clk);
    endtask

    // One well-formed run of random content closed by a final sample.
    task automatic random_run(int len);
        int                         mode;
        int                         base;
        int                         step;
        int                         pick;
        logic signed [SAMPLE_W-1:0] value;
        logic [WIN_W-1:0]           weight;
        mode = $urandom_range(0, 3);
        base = $urandom;
        step = $urandom_range(0, 4000);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: value = $urandom;
                // Rising trend forces long merge chains.
                1: value = base + i * step + $urandom_range(0, 3000) - 1500;
                // Falling trend keeps most pools apart.
                2: value = base - i * step + $urandom_range(0, 3000) - 1500;
                default:
                begin
                    pick = $urandom_range(0, 3);
                    value = (pick == 0) ? 32'sh8000_0000 :
                            (pick == 1) ? 32'sh7FFF_FFFF :
                            (pick == 2) ? 32'sh0000_0000 : -32'sd1;
                end
            endcase
            pick = $urandom_range(0, 15);
            weight = (pick == 0) ? 16'h0000 :
                     (pick == 1) ? 16'h0100 :
                     (pick == 2) ? 16'hFFFF : 16'($urandom_range(1, 65535));
            send_sample(value, weight, ($urandom_range(0, 4) == 0), (i == len - 1));
        end
        loaded_total += (len < MAX_SAMPLES) ? len : MAX_SAMPLES;
    endtask

    // Main stimulus.
    initial
    begin : stimulus
        int run_len;
        int run_idx;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single sample at the extremes of value and weight.
        send_sample(32'sh7FFF_FFFF, 16'hFFFF, 1'b0, 1'b1);
        // Rising run from the most negative value with a zero weight: all pools merge.
        send_sample(32'sh8000_0000, 16'h0000, 1'b0, 1'b0);
        send_sample(32'sh0000_0000, 16'h0100, 1'b0, 1'b0);
        send_sample(32'sh7FFF_FFFF, 16'hFFFF, 1'b0, 1'b1);
        wait_drained();
        // Negative mean that is not exact must round down.
        send_sample(-32'sd1, 16'h0001, 1'b0, 1'b0);
        send_sample(32'sh0000_0000, 16'h0002, 1'b0, 1'b1);
        // Segment boundaries stop merges that would otherwise happen.
        send_sample(32'sh0064_0000, 16'h0100, 1'b0, 1'b0);
        send_sample(32'sh012C_0000, 16'h0100, 1'b1, 1'b0);
        send_sample(32'sh01F4_0000, 16'h0200, 1'b0, 1'b0);
        send_sample(32'sh00C8_0000, 16'h0100, 1'b0, 1'b0);
        send_sample(32'sh02BC_0000, 16'h0100, 1'b1, 1'b0);
        send_sample(32'sh02BC_0000, 16'h0100, 1'b0, 1'b0);
        send_sample(32'sh0000_0000, 16'h0300, 1'b0, 1'b1);
        // Equal means merge.
        send_sample(32'sh0001_0000, 16'h0100, 1'b0, 1'b0);
        send_sample(32'sh0001_0000, 16'h0200, 1'b0, 1'b1);
        // Strictly falling run keeps one pool per sample.
        send_sample(32'sh0003_0000, 16'h0100, 1'b0, 1'b0);
        send_sample(32'sh0002_0000, 16'h0100, 1'b0, 1'b0);
        send_sample(32'sh0001_0000, 16'h0100, 1'b0, 1'b1);
        loaded_total = 18;

        // Random runs: the first overflows capacity, the second fills it exactly.
        run_idx = 0;
        while (loaded_total < ITEM_TARGET)
        begin
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            if (run_idx == 0)
                run_len = MAX_SAMPLES + 3;
            else if (run_idx == 1)
                run_len = MAX_SAMPLES;
            else if ($urandom_range(0, 9) == 0)
                run_len = $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 6);
            else
                run_len = $urandom_range(1, 12);
            random_run(run_len);
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            run_idx++;
        end

        // Drain and let the block settle before the verdict.
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fit_model.errors == 0 && fit_model.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
